### rtl/core/stbt_pkg.sv
// shared types and constants of the stopwatch timer bank
`default_nettype none

package stbt_pkg;

    // defaults of the top level parameters
    localparam int NUM_TIMERS_DEF = 16;
    localparam int TPS_DEF        = 60;

    // time conversion constants
    localparam int SECS_PER_MIN   = 60;
    localparam int MINS_PER_HOUR  = 60;
    localparam int CENTI          = 100;

    // output field widths
    localparam int HOURS_W        = 15;
    localparam int MINUTES_W      = 6;
    localparam int SECONDS_W      = 6;
    localparam int HUNDREDTHS_W   = 7;
    localparam logic [HOURS_W-1:0] HOURS_MAX = '1;

    // beats from the conversion input to its output register
    localparam int SPLIT_LAT      = 10;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_READ  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  timer_index;
        logic [31:0] user_ticks_now;
        logic [31:0] system_ticks_now;
        logic        give_named;
    } in_item_t;

    typedef struct packed {
        logic [HOURS_W-1:0]      user_hours;
        logic [MINUTES_W-1:0]    user_minutes;
        logic [SECONDS_W-1:0]    user_seconds;
        logic [HUNDREDTHS_W-1:0] user_hundredths;
        logic [HOURS_W-1:0]      sys_hours;
        logic [MINUTES_W-1:0]    sys_minutes;
        logic [SECONDS_W-1:0]    sys_seconds;
        logic [HUNDREDTHS_W-1:0] sys_hundredths;
        logic                    is_named;
    } out_item_t;

    // one timer entry of the bank
    typedef struct packed {
        logic [31:0] user_accum;
        logic [31:0] user_stamp;
        logic [31:0] sys_accum;
        logic [31:0] sys_stamp;
        logic        named;
    } row_t;

    // one accumulator split into clock fields
    typedef struct packed {
        logic [HOURS_W-1:0]      hours;
        logic [MINUTES_W-1:0]    minutes;
        logic [SECONDS_W-1:0]    seconds;
        logic [HUNDREDTHS_W-1:0] hundredths;
    } time_t;

endpackage

`default_nettype wire

### rtl/core/stbt_cdiv.sv
// three stage divider by a constant: reciprocal multiply, back multiply, one correction
`default_nettype none

module stbt_cdiv #(
    parameter int WIDTH   = 32,
    parameter int DIVISOR = 60,
    parameter int RW      = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] dividend,
    output logic      [WIDTH-1:0] quotient,
    output logic      [RW-1:0]    remainder
);

    // floor(2^32 / divisor), held to 32 bits; estimate is the quotient or one short
    localparam longint unsigned RECIP_FULL = 64'h1_0000_0000 / DIVISOR;
    localparam logic [31:0] RECIP =
        (RECIP_FULL > 64'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(RECIP_FULL);
    localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

    logic [WIDTH+31:0] prod;
    logic [WIDTH-1:0]  x_a_reg;
    logic [WIDTH-1:0]  q_a_reg;
    logic [WIDTH-1:0]  x_b_reg;
    logic [WIDTH-1:0]  q_b_reg;
    logic [WIDTH-1:0]  qd_b_reg;
    logic [WIDTH-1:0]  diff;
    logic              fix;
    logic [WIDTH-1:0]  quotient_reg;
    logic [RW-1:0]     remainder_reg;

    assign prod = (WIDTH+32)'(dividend) * (WIDTH+32)'(RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_a_reg <= dividend;
            q_a_reg <= prod[WIDTH+31:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_b_reg  <= x_a_reg;
            q_b_reg  <= q_a_reg;
            qd_b_reg <= q_a_reg * DIV_W;
        end
    end

    // remainder stays below twice the divisor
    assign diff = x_b_reg - qd_b_reg;
    assign fix  = (diff >= DIV_W);

    always_ff @(posedge aclk) begin
        if (en) begin
            quotient_reg  <= q_b_reg + WIDTH'(fix);
            remainder_reg <= fix ? RW'(diff - DIV_W) : RW'(diff);
        end
    end

    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

endmodule

`default_nettype wire

### rtl/core/stbt_split.sv
// pipelined conversion of a tick count to hours, minutes, seconds and hundredths
`default_nettype none

module stbt_split #(
    parameter int TICKS_PER_SECOND = stbt_pkg::TPS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [31:0]   ticks,
    output stbt_pkg::time_t    tm
);

    import stbt_pkg::*;

    localparam int TPS_RW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int HIN_W  = $clog2(TICKS_PER_SECOND * CENTI + 1);
    localparam logic [HIN_W-1:0] HALF  = HIN_W'(TICKS_PER_SECOND / 2);
    localparam logic [HIN_W-1:0] HUNDR = HIN_W'(CENTI);

    logic [31:0]             secs;
    logic [TPS_RW-1:0]       frac;
    logic [31:0]             mins;
    logic [MINUTES_W-1:0]    sec_part;
    logic [31:0]             hrs;
    logic [MINUTES_W-1:0]    min_part;
    logic [HIN_W-1:0]        hin_reg;
    logic [HIN_W-1:0]        hund_q;
    logic [5:0]              unused_rem;
    logic [SECONDS_W-1:0]    sec_d_reg [3];
    logic [HUNDREDTHS_W-1:0] hund_d_reg [2];
    time_t                   tm_reg;
    logic [TPS_RW-1:0]       hund_rem;

    // ticks to whole seconds and leftover ticks
    stbt_cdiv #(.WIDTH(32), .DIVISOR(TICKS_PER_SECOND)) u_div_tick (
        .aclk      (aclk),
        .en        (en),
        .dividend  (ticks),
        .quotient  (secs),
        .remainder (frac)
    );

    // seconds to minutes
    stbt_cdiv #(.WIDTH(32), .DIVISOR(SECS_PER_MIN), .RW(SECONDS_W)) u_div_sec (
        .aclk      (aclk),
        .en        (en),
        .dividend  (secs),
        .quotient  (mins),
        .remainder (sec_part)
    );

    // minutes to hours
    stbt_cdiv #(.WIDTH(32), .DIVISOR(MINS_PER_HOUR), .RW(MINUTES_W)) u_div_min (
        .aclk      (aclk),
        .en        (en),
        .dividend  (mins),
        .quotient  (hrs),
        .remainder (min_part)
    );

    // rounded hundredths of the leftover ticks
    always_ff @(posedge aclk) begin
        if (en) begin
            hin_reg <= HIN_W'(HIN_W'(frac) * HUNDR + HALF);
        end
    end

    stbt_cdiv #(.WIDTH(HIN_W), .DIVISOR(TICKS_PER_SECOND)) u_div_hund (
        .aclk      (aclk),
        .en        (en),
        .dividend  (hin_reg),
        .quotient  (hund_q),
        .remainder (hund_rem)
    );

    assign unused_rem = 6'(hund_rem);

    // line up seconds and hundredths with the hours divider
    always_ff @(posedge aclk) begin
        if (en) begin
            sec_d_reg[0]  <= sec_part;
            sec_d_reg[1]  <= sec_d_reg[0];
            sec_d_reg[2]  <= sec_d_reg[1];
            hund_d_reg[0] <= HUNDREDTHS_W'(hund_q);
            hund_d_reg[1] <= hund_d_reg[0];
        end
    end

    // output register, hours saturate
    always_ff @(posedge aclk) begin
        if (en) begin
            tm_reg.hours      <= (hrs > 32'(HOURS_MAX)) ? HOURS_MAX : HOURS_W'(hrs);
            tm_reg.minutes    <= min_part;
            tm_reg.seconds    <= sec_d_reg[2];
            tm_reg.hundredths <= hund_d_reg[1] | HUNDREDTHS_W'(unused_rem & 6'd0);
        end
    end

    assign tm = tm_reg;

endmodule

`default_nettype wire

### rtl/core/stbt_bank.sv
// timer entry store with registered read, write bypass and per entry valid bits
`default_nettype none

module stbt_bank #(
    parameter int NUM_TIMERS = stbt_pkg::NUM_TIMERS_DEF,
    parameter int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire stbt_pkg::row_t    wr_data,
    output stbt_pkg::row_t         rd_data
);

    import stbt_pkg::*;

    row_t                  mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] valid_reg;
    row_t                  rd_row_reg;
    logic                  rd_valid_reg;
    logic                  bypass;

    assign bypass = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= bypass ? wr_data : mem[rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= bypass ? 1'b1 : valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_row_reg : '0;

endmodule

`default_nettype wire

### rtl/core/stopwatch_timer_bank_top.sv
// top level of the stopwatch timer bank
`default_nettype none

// A bank of NUM_TIMERS stopwatch timers, each with a user and a system tick
// accumulator, two start stamps and a named flag. One beat on s_ carries an
// operation (clear, start, stop, read) for one timer; only a read returns a
// beat on m_, holding both accumulators as hours, minutes, seconds and rounded
// hundredths at TICKS_PER_SECOND ticks per second, plus the flag. A timer index
// at or beyond NUM_TIMERS is ignored by clear, start and stop and reads as all
// zero. One beat is taken every cycle unless a read stalls: clear, start and
// stop are a single read-modify-write of one entry through the bank's one
// write port, and a read result goes from the registered entry read through
// the divider pipeline to m_. While a result waits on m_ the conversion
// pipeline holds, and a read then blocks the input at the first stage. Reset
// is immediate: per entry valid bits stand in for a clearing pass.
module stopwatch_timer_bank_top #(
    parameter int NUM_TIMERS       = stbt_pkg::NUM_TIMERS_DEF,
    parameter int TICKS_PER_SECOND = stbt_pkg::TPS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire stbt_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output stbt_pkg::out_item_t    m_item
);

    import stbt_pkg::*;

    localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // first stage: the accepted beat, aligned with the entry read
    logic                 s1_v_reg;
    in_item_t             s1_item_reg;
    logic                 s1_ok_reg;
    logic                 accept;
    logic                 s1_is_read;
    logic                 s1_leave;
    logic                 conv_en;

    // bank access
    row_t                 bank_row;
    row_t                 cur_row;
    row_t                 row_next;
    logic                 wr_en;

    // conversion pipeline tracking
    logic [SPLIT_LAT-1:0] vld_reg;
    logic [SPLIT_LAT-1:0] flag_reg;
    time_t                user_tm;
    time_t                sys_tm;

    // conversion pipeline moves whenever the output slot is free or being taken
    assign conv_en    = !vld_reg[SPLIT_LAT-1] || m_ready;
    assign s1_is_read = (s1_item_reg.kind == OP_READ);
    // updates retire at once, a read waits for the conversion pipeline
    assign s1_leave   = !s1_is_read || conv_en;
    assign s_ready    = !s1_v_reg || s1_leave;
    assign accept     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (s_ready) begin
            s1_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_item;
            s1_ok_reg   <= (32'(s_item.timer_index) < 32'(NUM_TIMERS));
        end
    end

    stbt_bank #(.NUM_TIMERS(NUM_TIMERS), .ADDR_W(ADDR_W)) u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(s_item.timer_index)),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(s1_item_reg.timer_index)),
        .wr_data (row_next),
        .rd_data (bank_row)
    );

    // out of range timers look like an all zero entry
    assign cur_row = s1_ok_reg ? bank_row : '0;

    // entry update; clear keeps the stamps, differences and sums wrap
    always_comb begin
        row_next = cur_row;
        case (s1_item_reg.kind)
            OP_CLEAR: begin
                row_next.user_accum = '0;
                row_next.sys_accum  = '0;
                row_next.named      = s1_item_reg.give_named;
            end
            OP_START: begin
                row_next.user_stamp = s1_item_reg.user_ticks_now;
                row_next.sys_stamp  = s1_item_reg.system_ticks_now;
            end
            OP_STOP: begin
                row_next.user_accum = cur_row.user_accum
                                    + (s1_item_reg.user_ticks_now - cur_row.user_stamp);
                row_next.sys_accum  = cur_row.sys_accum
                                    + (s1_item_reg.system_ticks_now - cur_row.sys_stamp);
            end
            default: begin
            end
        endcase
    end

    assign wr_en = s1_v_reg && s1_ok_reg && !s1_is_read;

    // two converters side by side, one per accumulator
    stbt_split #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_split_user (
        .aclk  (aclk),
        .en    (conv_en),
        .ticks (cur_row.user_accum),
        .tm    (user_tm)
    );

    stbt_split #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_split_sys (
        .aclk  (aclk),
        .en    (conv_en),
        .ticks (cur_row.sys_accum),
        .tm    (sys_tm)
    );

    // valid and named flag travel beside the converters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (conv_en) begin
            vld_reg <= {vld_reg[SPLIT_LAT-2:0], s1_v_reg && s1_is_read};
        end
    end

    always_ff @(posedge aclk) begin
        if (conv_en) begin
            flag_reg <= {flag_reg[SPLIT_LAT-2:0], cur_row.named};
        end
    end

    // result beat, every field straight from a register
    assign m_valid = vld_reg[SPLIT_LAT-1];

    always_comb begin
        m_item.user_hours      = user_tm.hours;
        m_item.user_minutes    = user_tm.minutes;
        m_item.user_seconds    = user_tm.seconds;
        m_item.user_hundredths = user_tm.hundredths;
        m_item.sys_hours       = sys_tm.hours;
        m_item.sys_minutes     = sys_tm.minutes;
        m_item.sys_seconds     = sys_tm.seconds;
        m_item.sys_hundredths  = sys_tm.hundredths;
        m_item.is_named        = flag_reg[SPLIT_LAT-1];
    end

endmodule

`default_nettype wire

### rtl/core/stbt_checker.sv
// port level checks on the stopwatch timer bank and their binding
`default_nettype none

module stbt_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire stbt_pkg::in_item_t  s_item,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire stbt_pkg::out_item_t m_item
);

    import stbt_pkg::*;

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input beat changed while stalled");

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result beat changed while stalled");

    // reset empties the block
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // input never stalls while the output slot is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with output free");

    // split fields stay in their clock ranges
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.user_minutes < 6'd60) && (m_item.user_seconds < 6'd60)
                 && (m_item.user_hundredths < 7'd100) && (m_item.sys_minutes < 6'd60)
                 && (m_item.sys_seconds < 6'd60) && (m_item.sys_hundredths < 7'd100))
        else $error("result field out of range");

endmodule

bind stopwatch_timer_bank_top stbt_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

### tb/stopwatch_timer_bank_top_tb.sv
// self-checking testbench of the stopwatch timer bank top level
`timescale 1ns / 100ps

module stopwatch_timer_bank_top_tb;
    import stbt_pkg::*;

    localparam int  BANK_DEPTH   = NUM_TIMERS_DEF;
    localparam int  TICK_RATE    = TPS_DEF;
    localparam int  RANDOM_ITEMS = 800;
    localparam int  MAX_IDLE     = 16;
    // time limit of the whole run, ample for the slowest run
    localparam real RUN_LIMIT_NS = 10_000_000.0;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // shadow copy of the timer bank, updated on every accepted input beat
    logic [31:0] user_total [BANK_DEPTH];
    logic [31:0] user_mark  [BANK_DEPTH];
    logic [31:0] sys_total  [BANK_DEPTH];
    logic [31:0] sys_mark   [BANK_DEPTH];
    logic        named_bit  [BANK_DEPTH];

    // read results still owed by the block, oldest first
    out_item_t pending_reads [$];

    // idling switches, flipped per phase so that busy and quiet stretches both occur
    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;

    int beats_sent    = 0;
    int reads_checked = 0;
    int error_count   = 0;

    stopwatch_timer_bank_top #(
        .NUM_TIMERS       (BANK_DEPTH),
        .TICKS_PER_SECOND (TICK_RATE)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // break a tick count into clock fields, hundredths rounded to nearest
    function automatic time_t ticks_to_clock(input logic [31:0] ticks);
        time_t       clk_fields;
        int unsigned rem_ticks;
        int unsigned whole_secs;
        int unsigned whole_mins;
        int unsigned whole_hours;
        rem_ticks   = ticks % TICK_RATE;
        whole_secs  = ticks / TICK_RATE;
        whole_mins  = whole_secs / SECS_PER_MIN;
        whole_hours = whole_mins / MINS_PER_HOUR;
        if (whole_hours > 32'(HOURS_MAX))
            whole_hours = 32'(HOURS_MAX);
        clk_fields.hours      = HOURS_W'(whole_hours);
        clk_fields.minutes    = MINUTES_W'(whole_mins % MINS_PER_HOUR);
        clk_fields.seconds    = SECONDS_W'(whole_secs % SECS_PER_MIN);
        clk_fields.hundredths = HUNDREDTHS_W'((rem_ticks * CENTI + TICK_RATE / 2) / TICK_RATE);
        return clk_fields;
    endfunction

    // apply one accepted beat to the shadow bank, queueing a result for a read
    task automatic update_shadow_bank(input in_item_t it);
        out_item_t res;
        time_t     user_clk;
        time_t     sys_clk;
        bit        in_bank;
        in_bank = it.timer_index < BANK_DEPTH;
        case (it.kind)
            OP_CLEAR: begin
                if (in_bank) begin
                    user_total[it.timer_index] = '0;
                    sys_total[it.timer_index]  = '0;
                    named_bit[it.timer_index]  = it.give_named;
                end
            end
            OP_START: begin
                if (in_bank) begin
                    user_mark[it.timer_index] = it.user_ticks_now;
                    sys_mark[it.timer_index]  = it.system_ticks_now;
                end
            end
            OP_STOP: begin
                if (in_bank) begin
                    user_total[it.timer_index] += it.user_ticks_now - user_mark[it.timer_index];
                    sys_total[it.timer_index]  += it.system_ticks_now - sys_mark[it.timer_index];
                end
            end
            OP_READ: begin
                res = '0;
                if (in_bank) begin
                    user_clk            = ticks_to_clock(user_total[it.timer_index]);
                    sys_clk             = ticks_to_clock(sys_total[it.timer_index]);
                    res.user_hours      = user_clk.hours;
                    res.user_minutes    = user_clk.minutes;
                    res.user_seconds    = user_clk.seconds;
                    res.user_hundredths = user_clk.hundredths;
                    res.sys_hours       = sys_clk.hours;
                    res.sys_minutes     = sys_clk.minutes;
                    res.sys_seconds     = sys_clk.seconds;
                    res.sys_hundredths  = sys_clk.hundredths;
                    res.is_named        = named_bit[it.timer_index];
                end
                pending_reads.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------

    function automatic in_item_t make_item(input kind_t k, input logic [3:0] idx,
                                           input logic [31:0] u_now,
                                           input logic [31:0] s_now, input logic nm);
        in_item_t it;
        it.kind             = k;
        it.timer_index      = idx;
        it.user_ticks_now   = u_now;
        it.system_ticks_now = s_now;
        it.give_named       = nm;
        return it;
    endfunction

    // send one beat; called and returning at a falling edge, valid held until taken
    task automatic send_beat(input in_item_t it);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        update_shadow_bank(it);
        beats_sent++;
        @(negedge aclk);
    endtask

    // ignored fields carry random values so that they are seen to be ignored
    task automatic send_clear(input logic [3:0] idx, input logic nm);
        send_beat(make_item(OP_CLEAR, idx, $urandom, $urandom, nm));
    endtask

    task automatic send_start(input logic [3:0] idx, input logic [31:0] u_now,
                              input logic [31:0] s_now);
        send_beat(make_item(OP_START, idx, u_now, s_now, 1'($urandom_range(0, 1))));
    endtask

    task automatic send_stop(input logic [3:0] idx, input logic [31:0] u_now,
                             input logic [31:0] s_now);
        send_beat(make_item(OP_STOP, idx, u_now, s_now, 1'($urandom_range(0, 1))));
    endtask

    task automatic send_read(input logic [3:0] idx);
        send_beat(make_item(OP_READ, idx, $urandom, $urandom, 1'($urandom_range(0, 1))));
    endtask

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            error_count++;
        end
    endtask

    initial begin : result_checker
        int        stall;
        out_item_t want;
        out_item_t got;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            got = m_item;
            if (pending_reads.size() == 0) begin
                $error("result beat with no read outstanding");
                error_count++;
            end else begin
                want = pending_reads.pop_front();
                check_field("user_hours",      32'(want.user_hours),
                            32'(got.user_hours));
                check_field("user_minutes",    32'(want.user_minutes),
                            32'(got.user_minutes));
                check_field("user_seconds",    32'(want.user_seconds),
                            32'(got.user_seconds));
                check_field("user_hundredths", 32'(want.user_hundredths),
                            32'(got.user_hundredths));
                check_field("sys_hours",       32'(want.sys_hours),
                            32'(got.sys_hours));
                check_field("sys_minutes",     32'(want.sys_minutes),
                            32'(got.sys_minutes));
                check_field("sys_seconds",     32'(want.sys_seconds),
                            32'(got.sys_seconds));
                check_field("sys_hundredths",  32'(want.sys_hundredths),
                            32'(got.sys_hundredths));
                check_field("is_named",        32'(want.is_named),
                            32'(got.is_named));
                reads_checked++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // untouched timers read zero; a stop with no start measures from a zero stamp
    task automatic test_fresh_timers();
        send_read(4'd0);
        send_read(4'd15);
        send_stop(4'd3, 32'hFFFF_FFFF, 32'd12345);
        send_read(4'd3);
    endtask

    // full-range counts, wrapping differences and the rounding of hundredths
    task automatic test_count_extremes();
        // largest accumulator: 19884 hours, below the hours limit, 15 ticks left over
        send_clear(4'd15, 1'b1);
        send_start(4'd15, 32'h0000_0000, 32'h0000_0000);
        send_stop(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_read(4'd15);
        // counter wraps between start and stop
        send_clear(4'd1, 1'b0);
        send_start(4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_stop(4'd1, 32'h0000_003B, 32'h0000_0010);
        send_read(4'd1);
        // 59 ticks rounds to 98, then a second stop adds an hour less a tick to the user count
        send_clear(4'd2, 1'b1);
        send_start(4'd2, 32'd0, 32'd100);
        send_stop(4'd2, 32'd59, 32'd130);
        send_read(4'd2);
        send_start(4'd2, 32'd1000, 32'd0);
        send_stop(4'd2, 32'd1000 + 32'd215999, 32'd216000);
        send_read(4'd2);
    endtask

    // a clear zeroes the totals and sets the flag but does not touch the start stamps
    task automatic test_clear_keeps_stamps();
        send_start(4'd4, 32'd1000, 32'd2000);
        send_clear(4'd4, 1'b1);
        send_stop(4'd4, 32'd1600, 32'd2060);
        send_read(4'd4);
        send_clear(4'd4, 1'b0);
        send_read(4'd4);
    endtask

    // short or full-range gap between two tick counts
    function automatic logic [31:0] tick_step();
        return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 500000);
    endfunction

    // mostly whole sessions on one timer (clear, start/stop pairs, read) with
    // random counts, the rest single beats of any kind
    task automatic test_random_sessions(input int beat_count);
        int          stop_at;
        logic [3:0]  idx;
        logic [31:0] u_now;
        logic [31:0] s_now;
        stop_at = beats_sent + beat_count;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                idx   = 4'($urandom_range(0, BANK_DEPTH - 1));
                u_now = $urandom;
                s_now = $urandom;
                if ($urandom_range(0, 3) != 0)
                    send_clear(idx, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 3)) begin
                    send_start(idx, u_now, s_now);
                    u_now += tick_step();
                    s_now += tick_step();
                    if ($urandom_range(0, 7) != 0)
                        send_stop(idx, u_now, s_now);
                end
                send_read(idx);
            end else begin
                send_beat(make_item(kind_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                    $urandom, $urandom, 1'($urandom_range(0, 1))));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial begin : test_sequence
        int waited;
        for (int i = 0; i < BANK_DEPTH; i++) begin
            user_total[i] = '0;
            user_mark[i]  = '0;
            sys_total[i]  = '0;
            sys_mark[i]   = '0;
            named_bit[i]  = 1'b0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part back to back, no idling on either side
        test_fresh_timers();
        test_count_extremes();
        test_clear_keeps_stamps();

        // random part in phases so that idling and full-rate stretches both occur
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        test_random_sessions(RANDOM_ITEMS / 4);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_sessions(RANDOM_ITEMS / 4);
        receiver_idles = 1'b1;
        test_random_sessions(RANDOM_ITEMS / 4);
        sender_idles   = 1'b1;
        receiver_idles = 1'b0;
        test_random_sessions(RANDOM_ITEMS / 4);
        s_valid <= 1'b0;

        // drain, then watch a while longer for stray result beats
        waited = 0;
        while (pending_reads.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4 * SPLIT_LAT) @(posedge aclk);
        if (pending_reads.size() != 0) begin
            $error("%0d read results never arrived", pending_reads.size());
            error_count++;
        end

        $display("covered %0d operation beats over all timers, %0d read results checked",
                 beats_sent, reads_checked);
        $display("directed edge cases plus random sessions, with and without idling");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
